[hdl/pfsm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the page free-slot map.
// Used by pfsm_cell and page_free_slot_map_unit; depends on nothing.

package pfsm_pkg;

   localparam int MAX_PAGES  = 256;
   localparam int PAGE_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int TRACK_W    = $clog2(MAX_PAGES + 1);
   localparam int CNT_W      = 13;
   localparam int PID_W      = 32;
   localparam int RSP_PAGE_W = 8;

   localparam logic [CNT_W-1:0] LIM_MIN   = CNT_W'(1);
   localparam logic [CNT_W-1:0] LIM_MAX   = CNT_W'(4096);
   localparam logic [CNT_W-1:0] LIM_RESET = CNT_W'(64);

   typedef enum logic [1:0] {
      OP_GET  = 2'd0,
      OP_USE  = 2'd1,
      OP_FREE = 2'd2,
      OP_INIT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_FREE    = 3'd1,
      ST_FULLY_FREE = 3'd2,
      ST_UNTRACKED  = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   typedef struct packed {
      op_type           operation;
      logic [PID_W-1:0] page_id;
   } req_type;

   typedef struct packed {
      logic [RSP_PAGE_W-1:0] result_page;
      status_type            status;
      logic                  page_appended;
      logic [CNT_W-1:0]      slots_left;
   } rsp_type;

   // request travelling down the row of cells
   typedef struct packed {
      logic                  valid;
      op_type                operation;
      logic [PAGE_W-1:0]     target;
      logic [TRACK_W-1:0]    tracked;
      logic [CNT_W-1:0]      limit;
      logic                  done;
      status_type            status;
      logic [RSP_PAGE_W-1:0] page;
      logic                  appended;
      logic [CNT_W-1:0]      left;
   } cmd_type;

endpackage

[hdl/pfsm_cell.sv]
`timescale 1ns / 1ps
// One cell of the row: holds the free-slot count of one page and acts on a
// passing request. Depends on pfsm_pkg.

module pfsm_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [pfsm_pkg::PAGE_W-1:0] cell_index,
   input  pfsm_pkg::cmd_type        cmd_i,
   output pfsm_pkg::cmd_type        cmd_o
);

   logic [pfsm_pkg::CNT_W-1:0] count_ff;
   logic [pfsm_pkg::CNT_W-1:0] count_in;
   pfsm_pkg::cmd_type          cmd_ff;
   pfsm_pkg::cmd_type          cmd_in;
   logic                       tracked_here;
   logic                       open;

   assign tracked_here = pfsm_pkg::TRACK_W'(cell_index) < cmd_i.tracked;
   assign open         = cmd_i.valid && !cmd_i.done;

   always_comb begin
      cmd_in   = cmd_i;
      count_in = count_ff;
      if (open) begin
         unique case (cmd_i.operation)
            pfsm_pkg::OP_GET: begin
               if (!tracked_here) begin
                  count_in        = cmd_i.limit;
                  cmd_in.done     = 1'b1;
                  cmd_in.status   = pfsm_pkg::ST_OK;
                  cmd_in.page     = pfsm_pkg::RSP_PAGE_W'(cell_index);
                  cmd_in.appended = 1'b1;
                  cmd_in.left     = cmd_i.limit;
               end else if (count_ff != '0) begin
                  cmd_in.done     = 1'b1;
                  cmd_in.status   = pfsm_pkg::ST_OK;
                  cmd_in.page     = pfsm_pkg::RSP_PAGE_W'(cell_index);
                  cmd_in.appended = 1'b0;
                  cmd_in.left     = count_ff;
               end
            end
            pfsm_pkg::OP_USE: begin
               if (cmd_i.target == cell_index) begin
                  cmd_in.done     = 1'b1;
                  cmd_in.page     = pfsm_pkg::RSP_PAGE_W'(cell_index);
                  cmd_in.appended = 1'b0;
                  if (count_ff == '0) begin
                     cmd_in.status = pfsm_pkg::ST_NO_FREE;
                     cmd_in.left   = '0;
                  end else begin
                     count_in      = count_ff - pfsm_pkg::CNT_W'(1);
                     cmd_in.status = pfsm_pkg::ST_OK;
                     cmd_in.left   = count_ff - pfsm_pkg::CNT_W'(1);
                  end
               end
            end
            pfsm_pkg::OP_FREE: begin
               if (cmd_i.target == cell_index) begin
                  cmd_in.done     = 1'b1;
                  cmd_in.page     = pfsm_pkg::RSP_PAGE_W'(cell_index);
                  cmd_in.appended = 1'b0;
                  if (count_ff >= cmd_i.limit) begin
                     cmd_in.status = pfsm_pkg::ST_FULLY_FREE;
                     cmd_in.left   = count_ff;
                  end else begin
                     count_in      = count_ff + pfsm_pkg::CNT_W'(1);
                     cmd_in.status = pfsm_pkg::ST_OK;
                     cmd_in.left   = count_ff + pfsm_pkg::CNT_W'(1);
                  end
               end
            end
            pfsm_pkg::OP_INIT: begin
               if (cell_index == '0) begin
                  count_in        = cmd_i.limit;
                  cmd_in.done     = 1'b1;
                  cmd_in.status   = pfsm_pkg::ST_OK;
                  cmd_in.page     = '0;
                  cmd_in.appended = 1'b0;
                  cmd_in.left     = cmd_i.limit;
               end
            end
            default: begin
               cmd_in = cmd_i;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      if (reset) begin
         cmd_ff <= '0;
      end else begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_o = cmd_ff;

endmodule

[hdl/page_free_slot_map_unit.sv]
`timescale 1ns / 1ps
// Top level of the page free-slot map: issue register, row of pfsm_cell,
// result register with skid stage, page count and limit register. Depends on pfsm_pkg.
//
//   port group   direction  handshake              payload
//   req_         in         req_valid / req_stall  pfsm_pkg::req_type
//   rsp_         out        rsp_valid / rsp_stall  pfsm_pkg::rsp_type
//   csr_         in         csr_write_enable       13-bit slots per page
//
// A request passes the issue register and then one cell per cycle, one cell per page,
// before its result is registered in the output register or, when stalled, in the skid stage.
// One request is in the row at a time; the next is taken the cycle after the result
// leaves the row, provided the skid stage is empty.
// Reset empties the table and sets the limit to 64; the counts need no clearing.
// A stalled result waits in the output register, a second one in the skid stage.

module page_free_slot_map_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pfsm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pfsm_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_enable,
   input  logic [pfsm_pkg::CNT_W-1:0]    csr_write_data
);

   logic [pfsm_pkg::CNT_W-1:0]   limit_ff;
   logic [pfsm_pkg::CNT_W-1:0]   eff_limit;
   logic [pfsm_pkg::TRACK_W-1:0] tracked_ff;
   logic [pfsm_pkg::TRACK_W-1:0] tracked_in;
   logic                         busy_ff;
   logic                         busy_in;
   pfsm_pkg::cmd_type            issue_ff;
   pfsm_pkg::cmd_type            issue_in;
   pfsm_pkg::cmd_type            chain [pfsm_pkg::MAX_PAGES+1];
   pfsm_pkg::cmd_type            exit_cmd;
   pfsm_pkg::rsp_type            exit_rsp;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   pfsm_pkg::rsp_type            rsp_data_ff;
   pfsm_pkg::rsp_type            rsp_data_in;
   logic                         skid_valid_ff;
   logic                         skid_valid_in;
   pfsm_pkg::rsp_type            skid_data_ff;
   pfsm_pkg::rsp_type            skid_data_in;
   logic                         req_accept;
   logic                         rsp_free;
   logic                         untracked;

   assign req_stall  = busy_ff || skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      eff_limit = limit_ff;
      if (limit_ff < pfsm_pkg::LIM_MIN) begin
         eff_limit = pfsm_pkg::LIM_MIN;
      end else if (limit_ff > pfsm_pkg::LIM_MAX) begin
         eff_limit = pfsm_pkg::LIM_MAX;
      end
   end

   assign untracked = (req_data.operation == pfsm_pkg::OP_USE ||
                       req_data.operation == pfsm_pkg::OP_FREE) &&
                      (req_data.page_id >= pfsm_pkg::PID_W'(tracked_ff));

   always_comb begin
      issue_in           = issue_ff;
      issue_in.valid     = 1'b0;
      if (req_accept) begin
         issue_in.valid     = 1'b1;
         issue_in.operation = req_data.operation;
         issue_in.target    = pfsm_pkg::PAGE_W'(req_data.page_id);
         issue_in.tracked   = tracked_ff;
         issue_in.limit     = eff_limit;
         issue_in.done      = untracked;
         issue_in.status    = pfsm_pkg::ST_UNTRACKED;
         issue_in.page      = req_data.page_id[pfsm_pkg::RSP_PAGE_W-1:0];
         issue_in.appended  = 1'b0;
         issue_in.left      = '0;
      end
   end

   assign chain[0] = issue_ff;

   for (genvar k = 0; k < pfsm_pkg::MAX_PAGES; k++) begin : g_cell
      pfsm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (pfsm_pkg::PAGE_W'(k)),
         .cmd_i      (chain[k]),
         .cmd_o      (chain[k+1])
      );
   end

   assign exit_cmd = chain[pfsm_pkg::MAX_PAGES];

   always_comb begin
      if (exit_cmd.done) begin
         exit_rsp.result_page   = exit_cmd.page;
         exit_rsp.status        = exit_cmd.status;
         exit_rsp.page_appended = exit_cmd.appended;
         exit_rsp.slots_left    = exit_cmd.left;
      end else begin
         exit_rsp.result_page   = '0;
         exit_rsp.status        = pfsm_pkg::ST_TABLE_FULL;
         exit_rsp.page_appended = 1'b0;
         exit_rsp.slots_left    = '0;
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      tracked_in = tracked_ff;
      if (exit_cmd.valid) begin
         busy_in = 1'b0;
         if (exit_cmd.operation == pfsm_pkg::OP_INIT) begin
            tracked_in = pfsm_pkg::TRACK_W'(1);
         end else if (exit_cmd.done && exit_cmd.appended) begin
            tracked_in = tracked_ff + pfsm_pkg::TRACK_W'(1);
         end
      end
      if (req_accept) begin
         busy_in = 1'b1;
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (exit_cmd.valid) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = exit_rsp;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (exit_cmd.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = exit_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= pfsm_pkg::LIM_RESET;
         tracked_ff    <= '0;
         busy_ff       <= 1'b0;
         issue_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         tracked_ff    <= tracked_in;
         busy_ff       <= busy_in;
         issue_ff      <= issue_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_skid_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !busy_ff)
      else $error("skid stage holds a result while a request is in the row");

   a_exit_needs_busy: assert property (@(posedge clock) disable iff (reset)
      exit_cmd.valid |-> busy_ff)
      else $error("request left the row without one in flight");

   a_tracked_bound: assert property (@(posedge clock) disable iff (reset)
      tracked_ff <= pfsm_pkg::TRACK_W'(pfsm_pkg::MAX_PAGES))
      else $error("page count beyond table size");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (exit_cmd.valid && exit_cmd.done && exit_cmd.appended)
         |=> tracked_ff == $past(tracked_ff) + pfsm_pkg::TRACK_W'(1))
      else $error("append did not grow the page count");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for page_free_slot_map_unit: directed and random requests,
// every response checked against a behavioural model of the free-slot table.
// Depends on pfsm_pkg and the unit itself.

module tb;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   pfsm_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   pfsm_pkg::rsp_type              rsp_data;
   logic                           csr_write_enable = 1'b0;
   logic [pfsm_pkg::CNT_W-1:0]     csr_write_data = '0;

   // model of the slot table
   logic [pfsm_pkg::CNT_W-1:0]     slot_count [pfsm_pkg::MAX_PAGES];
   int unsigned                    page_total = 0;
   int unsigned                    last_given = 0;
   logic [pfsm_pkg::CNT_W-1:0]     limit_reg = pfsm_pkg::LIM_RESET;

   pfsm_pkg::rsp_type              slot_results_due [$];
   pfsm_pkg::rsp_type              want_rsp;
   int                             mismatch_count = 0;
   int                             burst_left = 0;
   int                             stall_hold = 0;
   bit                             stall_pick;

   page_free_slot_map_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic pfsm_pkg::rsp_type apply_request(pfsm_pkg::req_type r);
      pfsm_pkg::rsp_type          o;
      logic [pfsm_pkg::CNT_W-1:0] lim;
      int unsigned                i;
      bit                         found;
      o = '0;
      found = 1'b0;
      lim = (limit_reg < pfsm_pkg::LIM_MIN) ? pfsm_pkg::LIM_MIN :
            (limit_reg > pfsm_pkg::LIM_MAX) ? pfsm_pkg::LIM_MAX : limit_reg;
      case (r.operation)
         pfsm_pkg::OP_GET: begin
            for (i = 0; i < page_total; i++) begin
               if (!found && slot_count[i] != 0) begin
                  found = 1'b1;
                  o.result_page = pfsm_pkg::RSP_PAGE_W'(i);
                  o.slots_left = slot_count[i];
                  last_given = i;
               end
            end
            if (!found && page_total >= pfsm_pkg::MAX_PAGES) begin
               o.status = pfsm_pkg::ST_TABLE_FULL;
            end else if (!found) begin
               slot_count[page_total] = lim;
               o.result_page = pfsm_pkg::RSP_PAGE_W'(page_total);
               o.page_appended = 1'b1;
               o.slots_left = lim;
               last_given = page_total;
               page_total++;
            end
         end
         pfsm_pkg::OP_INIT: begin
            page_total = 1;
            slot_count[0] = lim;
            o.slots_left = lim;
            last_given = 0;
         end
         default: begin
            o.result_page = r.page_id[pfsm_pkg::RSP_PAGE_W-1:0];
            if (r.page_id >= page_total) begin
               o.status = pfsm_pkg::ST_UNTRACKED;
            end else if (r.operation == pfsm_pkg::OP_USE) begin
               if (slot_count[r.page_id] == 0) begin
                  o.status = pfsm_pkg::ST_NO_FREE;
               end else begin
                  slot_count[r.page_id] = slot_count[r.page_id] - 1'b1;
                  o.slots_left = slot_count[r.page_id];
               end
            end else if (slot_count[r.page_id] >= lim) begin
               o.status = pfsm_pkg::ST_FULLY_FREE;
               o.slots_left = slot_count[r.page_id];
            end else begin
               slot_count[r.page_id] = slot_count[r.page_id] + 1'b1;
               o.slots_left = slot_count[r.page_id];
            end
         end
      endcase
      return o;
   endfunction

   task automatic send_request(pfsm_pkg::op_type op, logic [pfsm_pkg::PID_W-1:0] pid);
      pfsm_pkg::req_type item;
      item.operation = op;
      item.page_id = pid;
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      slot_results_due = {slot_results_due, apply_request(item)};
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 12);
         req_valid <= 1'b0;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(240, 280)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (slot_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(logic [pfsm_pkg::CNT_W-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_reg = value;
   endtask

   task automatic test_empty_table();
      send_request(pfsm_pkg::OP_USE, 32'h0000_0000);
      send_request(pfsm_pkg::OP_FREE, 32'hFFFF_FFFF);
      send_request(pfsm_pkg::OP_USE, 32'h8000_0000);
      send_request(pfsm_pkg::OP_GET, $urandom());
      send_request(pfsm_pkg::OP_GET, $urandom());
      send_request(pfsm_pkg::OP_USE, 32'h0000_0000);
      send_request(pfsm_pkg::OP_FREE, 32'h0000_0000);
      send_request(pfsm_pkg::OP_FREE, 32'h0000_0000);
      send_request(pfsm_pkg::OP_USE, 32'h0000_0001);
      send_request(pfsm_pkg::OP_FREE, 32'h0000_0100);
      send_request(pfsm_pkg::OP_INIT, $urandom());
   endtask

   task automatic test_limit_extremes();
      set_limit(pfsm_pkg::CNT_W'(4096));
      send_request(pfsm_pkg::OP_INIT, 32'hFFFF_FFFF);
      send_request(pfsm_pkg::OP_USE, 32'h0);
      send_request(pfsm_pkg::OP_FREE, 32'h0);
      send_request(pfsm_pkg::OP_FREE, 32'h0);
      set_limit(pfsm_pkg::CNT_W'(8191));
      send_request(pfsm_pkg::OP_INIT, 32'h0);
      send_request(pfsm_pkg::OP_GET, 32'h0);
      set_limit(pfsm_pkg::CNT_W'(4097));
      send_request(pfsm_pkg::OP_FREE, 32'h0);
      set_limit(pfsm_pkg::CNT_W'(1));
      send_request(pfsm_pkg::OP_FREE, 32'h0);
      send_request(pfsm_pkg::OP_INIT, $urandom());
      send_request(pfsm_pkg::OP_USE, 32'h0);
      send_request(pfsm_pkg::OP_USE, 32'h0);
      send_request(pfsm_pkg::OP_GET, $urandom());
      send_request(pfsm_pkg::OP_FREE, 32'h0);
      send_request(pfsm_pkg::OP_FREE, 32'h0);
      send_request(pfsm_pkg::OP_USE, 32'h2);
      send_request(pfsm_pkg::OP_FREE, 32'h1);
   endtask

   task automatic test_table_full();
      int k;
      set_limit(pfsm_pkg::CNT_W'(0));
      send_request(pfsm_pkg::OP_INIT, $urandom());
      for (k = 0; k < pfsm_pkg::MAX_PAGES - 1; k++) begin
         send_request(pfsm_pkg::OP_USE, k);
         send_request(pfsm_pkg::OP_GET, $urandom());
      end
      send_request(pfsm_pkg::OP_USE, pfsm_pkg::MAX_PAGES - 1);
      send_request(pfsm_pkg::OP_GET, $urandom());
      send_request(pfsm_pkg::OP_USE, pfsm_pkg::MAX_PAGES - 1);
      send_request(pfsm_pkg::OP_FREE, pfsm_pkg::MAX_PAGES - 1);
      send_request(pfsm_pkg::OP_GET, $urandom());
      send_request(pfsm_pkg::OP_USE, 300);
      send_request(pfsm_pkg::OP_FREE, 17);
      send_request(pfsm_pkg::OP_GET, $urandom());
      send_request(pfsm_pkg::OP_GET, $urandom());
   endtask

   task automatic test_random_mix(int items);
      int                         phase;
      int                         k;
      int                         pick;
      logic [pfsm_pkg::PID_W-1:0] pid;
      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 5))
            0: set_limit(pfsm_pkg::CNT_W'(0));
            1: set_limit(pfsm_pkg::CNT_W'(8191));
            2: set_limit(pfsm_pkg::CNT_W'($urandom_range(1, 4)));
            3: set_limit(pfsm_pkg::CNT_W'($urandom_range(2, 16)));
            4: set_limit(pfsm_pkg::CNT_W'($urandom_range(1, 4096)));
            default: set_limit(pfsm_pkg::CNT_W'($urandom_range(4097, 8191)));
         endcase
         for (k = 0; k < items / 6; k++) begin
            if ($urandom_range(0, 99) < 2) drain_results();
            if (page_total == 0) pid = 0;
            else if ($urandom_range(0, 1) == 0) pid = last_given;
            else pid = $urandom_range(0, page_total - 1);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               send_request(pfsm_pkg::OP_GET, $urandom());
            end else if (pick < 60) begin
               send_request(pfsm_pkg::OP_USE, pid);
            end else if (pick < 85) begin
               send_request(pfsm_pkg::OP_FREE, pid);
            end else if (pick < 90) begin
               send_request(pick[0] ? pfsm_pkg::OP_USE : pfsm_pkg::OP_FREE, page_total);
            end else if (pick < 97) begin
               send_request(pick[0] ? pfsm_pkg::OP_USE : pfsm_pkg::OP_FREE, $urandom());
            end else begin
               send_request(pfsm_pkg::OP_INIT, $urandom());
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold == 0) begin
         stall_pick = ($urandom_range(0, 2) == 0);
         rsp_stall <= stall_pick;
         stall_hold <= stall_pick ? $urandom_range(1, 12) : $urandom_range(1, 60);
      end else begin
         stall_hold <= stall_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (slot_results_due.size() == 0) begin
            $display("%0t: unexpected response, actual page %0d status %0d", $time,
                     rsp_data.result_page, rsp_data.status);
            mismatch_count++;
         end else begin
            want_rsp = slot_results_due.pop_front();
            if (rsp_data.result_page !== want_rsp.result_page) begin
               $display("%0t: result_page expected %0d actual %0d", $time,
                        want_rsp.result_page, rsp_data.result_page);
               mismatch_count++;
            end
            if (rsp_data.status !== want_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want_rsp.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.page_appended !== want_rsp.page_appended) begin
               $display("%0t: page_appended expected %0d actual %0d", $time,
                        want_rsp.page_appended, rsp_data.page_appended);
               mismatch_count++;
            end
            if (rsp_data.slots_left !== want_rsp.slots_left) begin
               $display("%0t: slots_left expected %0d actual %0d", $time,
                        want_rsp.slots_left, rsp_data.slots_left);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("tb failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_limit_extremes();
      test_table_full();
      test_random_mix(1450);
      drain_results();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
